// ===== rtl/core/nearest_palette_color_match_defines.svh =====
// Assertion macros shared by the nearest palette color match RTL.
`ifndef NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH

// Clocked check on i_clk, masked while i_rst_n is low.
`define NPCM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: check failed");

// Same check with a caller-supplied message.
`define NPCM_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

// ===== rtl/core/npcm_pkg.sv =====
// Shared types and constants for the nearest palette color match block.
`timescale 1ns / 1ps

package npcm_pkg;

    localparam int PALETTE_DEPTH_DEF = 512;

    localparam int COLOR_W = 8;
    localparam int INDEX_W = 9;
    localparam int COUNT_W = 10;
    localparam int ID_W    = 10;
    localparam int DIST_W  = 18;   // 3 * 255^2 fits in 18 bits

    localparam logic [COUNT_W-1:0] ENTRIES_RESET = 10'd261;

    // APB register map: one register, selected by address bit 2
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic [0:0] REG_ENTRIES = 1'b0;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Word travelling down the cell chain
    typedef struct packed {
        logic               valid;
        t_op                op;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [DIST_W-1:0]  score;
    } t_token;

endpackage

// ===== rtl/core/npcm_cell.sv =====
// One palette cell: holds one entry, scores a passing query, forwards the word.
`timescale 1ns / 1ps

module npcm_cell #(
    parameter int IDX_W    = 9,
    parameter int CELL_IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic [npcm_pkg::COUNT_W-1:0]     i_count,
    input  npcm_pkg::t_token                 i_token,
    input  logic [IDX_W-1:0]                 i_win_idx,
    output npcm_pkg::t_token                 o_token,
    output logic [IDX_W-1:0]                 o_win_idx
);

    logic [3*npcm_pkg::COLOR_W-1:0] r_color;
    npcm_pkg::t_token               r_token;
    logic [IDX_W-1:0]               r_win_idx;

    npcm_pkg::t_token               n_token;
    logic [IDX_W-1:0]               n_win_idx;

    logic [npcm_pkg::COLOR_W-1:0]   w_dr, w_dg, w_db;
    logic [2*npcm_pkg::COLOR_W-1:0] w_sr, w_sg, w_sb;
    logic [npcm_pkg::DIST_W-1:0]    w_dist;
    logic                           w_take;
    logic                           w_write_hit;

    function automatic logic [npcm_pkg::COLOR_W-1:0] abs_diff(
        input logic [npcm_pkg::COLOR_W-1:0] a,
        input logic [npcm_pkg::COLOR_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        w_dr = abs_diff(r_color[3*npcm_pkg::COLOR_W-1:2*npcm_pkg::COLOR_W], i_token.red);
        w_dg = abs_diff(r_color[2*npcm_pkg::COLOR_W-1:npcm_pkg::COLOR_W], i_token.green);
        w_db = abs_diff(r_color[npcm_pkg::COLOR_W-1:0], i_token.blue);
        w_sr = w_dr * w_dr;
        w_sg = w_dg * w_dg;
        w_sb = w_db * w_db;
        w_dist = npcm_pkg::DIST_W'(w_sr) + npcm_pkg::DIST_W'(w_sg)
               + npcm_pkg::DIST_W'(w_sb);

        // Cell zero always wins against the open start; others need strictly less.
        w_take = i_token.valid && (i_token.op == npcm_pkg::OP_QUERY)
              && (32'(i_count) > CELL_IDX)
              && ((CELL_IDX == 0) || (w_dist < i_token.score));
        w_write_hit = i_token.valid && (i_token.op == npcm_pkg::OP_WRITE)
                   && (32'(i_token.index) == CELL_IDX);

        n_token   = i_token;
        n_win_idx = i_win_idx;
        if (w_take) begin
            n_token.score = w_dist;
            n_win_idx     = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && w_write_hit) begin
            r_color <= {i_token.red, i_token.green, i_token.blue};
        end
    end

    // Only the valid bit is reset; the payload just follows the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token.valid <= 1'b0;
        end else if (i_advance) begin
            r_token.valid <= n_token.valid;
        end
        if (i_advance) begin
            r_token.op    <= n_token.op;
            r_token.index <= n_token.index;
            r_token.red   <= n_token.red;
            r_token.green <= n_token.green;
            r_token.blue  <= n_token.blue;
            r_token.score <= n_token.score;
            r_win_idx     <= n_win_idx;
        end
    end

    assign o_token   = r_token;
    assign o_win_idx = r_win_idx;

endmodule

// ===== rtl/core/npcm_out.sv =====
// Result register at the chain tail: keeps query results, drops writes.
`timescale 1ns / 1ps

module npcm_out #(
    parameter int IDX_W = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  npcm_pkg::t_token              i_token,
    input  logic [IDX_W-1:0]              i_win_idx,
    input  logic                          i_ready,
    output logic                          o_advance,
    output logic                          o_valid,
    output logic [npcm_pkg::ID_W-1:0]     o_best_id
);

    logic                      r_valid;
    logic [npcm_pkg::ID_W-1:0] r_id;
    logic [31:0]               w_id_full;

    assign o_advance = !r_valid || i_ready;
    assign w_id_full = 32'(i_win_idx) + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_token.valid && (i_token.op == npcm_pkg::OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_id <= w_id_full[npcm_pkg::ID_W-1:0];
        end
    end

    assign o_valid   = r_valid;
    assign o_best_id = r_id;

endmodule

// ===== rtl/core/nearest_palette_color_match.sv =====
// Top level of the nearest palette color match block: cell chain, result stage, APB register.
//
// Use: push words on the input channel (i_valid / o_ready). A write word
// (i_op = write) stores red/green/blue at palette entry i_entry_index and
// returns nothing. A query word returns on the output channel (o_valid /
// i_ready) the id (index plus one) of the nearest of the first
// entries_in_use palette entries by squared RGB distance, lowest on a tie.
// After acceptance a query word passes the PALETTE_DEPTH cell registers and the result register.
// Throughput: one word per cycle while the receiver does not stall, set by the chain
// of PALETTE_DEPTH cells, one entry each, every word moving one cell a cycle; writes
// and queries stay in order because both ride the chain.
// When the receiver stalls with a result waiting, the whole chain freezes
// and o_ready drops until the result is taken.
// Reset (synchronous, i_rst_n low) empties the chain and the result stage
// and sets entries_in_use to 261; o_ready stays low while reset is held;
// palette contents stay undefined until written.
// entries_in_use is APB register 0 (byte address 0); write it
// only while no word is in flight.
`timescale 1ns / 1ps
`include "nearest_palette_color_match_defines.svh"

module nearest_palette_color_match #(
    parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic [npcm_pkg::INDEX_W-1:0]        i_entry_index,
    input  logic [npcm_pkg::COLOR_W-1:0]        i_red,
    input  logic [npcm_pkg::COLOR_W-1:0]        i_green,
    input  logic [npcm_pkg::COLOR_W-1:0]        i_blue,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [npcm_pkg::ID_W-1:0]           o_best_id,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [npcm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [npcm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [npcm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    npcm_pkg::t_token             w_chain [0:PALETTE_DEPTH];
    logic [IDX_W-1:0]             w_widx  [0:PALETTE_DEPTH];
    logic                         w_adv;
    logic [31:0]                  w_tail_id;
    logic [npcm_pkg::COUNT_W-1:0] r_entries;
    logic                         w_reg_sel;

    // ---- APB register: entries_in_use ----
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[npcm_pkg::REG_SEL_BIT] == npcm_pkg::REG_ENTRIES);
    assign prdata    = w_reg_sel ? npcm_pkg::APB_DATA_W'(r_entries) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= npcm_pkg::ENTRIES_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_entries <= pwdata[npcm_pkg::COUNT_W-1:0];
        end
    end

    // ---- chain head: build the word from the input ports ----
    always_comb begin
        w_chain[0].valid = i_valid;
        w_chain[0].op    = npcm_pkg::t_op'(i_op);
        w_chain[0].index = i_entry_index;
        w_chain[0].red   = i_red;
        w_chain[0].green = i_green;
        w_chain[0].blue  = i_blue;
        w_chain[0].score = '0;   // cell zero loads it on every searched query
    end
    assign w_widx[0] = '0;       // id 1 when no entry is searched

    // Accept whenever the chain moves; a bubble enters if i_valid is low.
    // Hold off the sender while reset is asserted.
    assign o_ready = w_adv && i_rst_n;

    // ---- cell chain: one palette entry per cell ----
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        npcm_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_advance  (w_adv),
            .i_count    (r_entries),
            .i_token    (w_chain[g]),
            .i_win_idx  (w_widx[g]),
            .o_token    (w_chain[g+1]),
            .o_win_idx  (w_widx[g+1])
        );
    end

    // ---- chain tail: hold query results, drop writes ----
    npcm_out #(
        .IDX_W (IDX_W)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_token    (w_chain[PALETTE_DEPTH]),
        .i_win_idx  (w_widx[PALETTE_DEPTH]),
        .i_ready    (i_ready),
        .o_advance  (w_adv),
        .o_valid    (o_valid),
        .o_best_id  (o_best_id)
    );

    assign w_tail_id = 32'(w_widx[PALETTE_DEPTH]) + 32'd1;

    // ---- checks ----
    `NPCM_ASSERT(a_write_no_result,
        (w_adv && w_chain[PALETTE_DEPTH].valid
         && w_chain[PALETTE_DEPTH].op == npcm_pkg::OP_WRITE) |=> !o_valid)
    `NPCM_ASSERT_MSG(a_query_result,
        (w_adv && w_chain[PALETTE_DEPTH].valid
         && w_chain[PALETTE_DEPTH].op == npcm_pkg::OP_QUERY)
        |=> (o_valid && o_best_id == $past(w_tail_id[npcm_pkg::ID_W-1:0])),
        "query result lost or altered at chain tail")
    `NPCM_ASSERT(a_stall_freezes_chain,
        !w_adv |=> $stable(w_chain[1].valid))
    `NPCM_ASSERT_MSG(a_cfg_write,
        (psel && penable && pwrite && w_reg_sel)
        |=> (r_entries == $past(pwdata[npcm_pkg::COUNT_W-1:0])),
        "entries_in_use not updated by APB write")

endmodule
